### hw/rtl/pdmq_pkg.sv
// Shared types and constants of the priority drop message queue.
package pdmq_pkg;

    localparam logic [2:0] SEV_DATA     = 3'd0;
    localparam logic [2:0] SEV_INFO     = 3'd1;
    localparam logic [2:0] SEV_CRITICAL = 3'd4;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [9:0] MAX_SIZE_RESET = 10'd500;

    localparam int unsigned ENTRY_W = 67;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT,
        ST_APPEND,
        ST_FLUSH_RD,
        ST_FLUSH_CAP,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic clear;
        logic scan;
        logic pick;
        logic shift;
        logic append;
        logic flush_rd;
        logic flush_cap;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       room;
        logic       empty;
        logic       sweep_done;
        logic       found;
    } status_t;

endpackage

### hw/rtl/priority_drop_message_queue_top.sv
// Top level of the priority drop message queue.
//  channel   direction  handshake               payload
//  command   in         start & !busy           action, msg_type, client_id, payload_tag
//  result    out        done (one cycle)        out_*, accepted, evicted*, queue_*
//  config    in         cfg_valid & cfg_ready   cfg_data (max_size)
// A full add scans every entry through the single RAM read port and is dropped if no
// entry can be evicted; an eviction also shifts the entries behind the victim.
// Reset empties the queue and loads max_size with 500.
// The receiver cannot stall; busy holds off commands until done.
module priority_drop_message_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  msg_type,
    input  logic [31:0] client_id,
    input  logic [31:0] payload_tag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    output logic        done,
    output logic        out_valid,
    output logic [2:0]  out_type,
    output logic [31:0] out_client,
    output logic [31:0] out_payload,
    output logic        accepted,
    output logic        evicted,
    output logic [2:0]  evicted_type,
    output logic        queue_empty,
    output logic [9:0]  queue_count
);

    pdmq_pkg::cmd_t    cmd;
    pdmq_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    pdmq_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .sts  (sts),
        .cmd  (cmd),
        .busy (busy)
    );

    pdmq_datapath #(
        .DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .action      (action),
        .msg_type    (msg_type),
        .client_id   (client_id),
        .payload_tag (payload_tag),
        .done        (done),
        .out_valid   (out_valid),
        .out_type    (out_type),
        .out_client  (out_client),
        .out_payload (out_payload),
        .accepted    (accepted),
        .evicted     (evicted),
        .evicted_type(evicted_type),
        .queue_empty (queue_empty),
        .queue_count (queue_count)
    );

endmodule

### hw/rtl/pdmq_ram.sv
// Generic single write port RAM with registered read.
module pdmq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/pdmq_ctrl.sv
// Sequencing state machine of the message queue.
module pdmq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pdmq_pkg::status_t sts,
    output pdmq_pkg::cmd_t    cmd,
    output logic              busy
);

    pdmq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdmq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdmq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pdmq_pkg::ST_DECODE;
                end
            end
            pdmq_pkg::ST_DECODE:
            begin
                case (sts.action)
                    pdmq_pkg::ACT_ADD:
                    begin
                        if (sts.room)
                        begin
                            state_next = pdmq_pkg::ST_APPEND;
                        end
                        else if (sts.empty)
                        begin
                            state_next = pdmq_pkg::ST_REPORT;
                        end
                        else
                        begin
                            state_next = pdmq_pkg::ST_SCAN;
                        end
                    end
                    pdmq_pkg::ACT_FLUSH:
                    begin
                        state_next = sts.empty ? pdmq_pkg::ST_REPORT : pdmq_pkg::ST_FLUSH_RD;
                    end
                    default:
                    begin
                        state_next = pdmq_pkg::ST_REPORT;
                    end
                endcase
            end
            pdmq_pkg::ST_SCAN:
            begin
                if (sts.sweep_done)
                begin
                    state_next = pdmq_pkg::ST_PICK;
                end
            end
            pdmq_pkg::ST_PICK:
            begin
                state_next = sts.found ? pdmq_pkg::ST_SHIFT : pdmq_pkg::ST_REPORT;
            end
            pdmq_pkg::ST_SHIFT:
            begin
                if (sts.sweep_done)
                begin
                    state_next = pdmq_pkg::ST_APPEND;
                end
            end
            pdmq_pkg::ST_APPEND:    state_next = pdmq_pkg::ST_REPORT;
            pdmq_pkg::ST_FLUSH_RD:  state_next = pdmq_pkg::ST_FLUSH_CAP;
            pdmq_pkg::ST_FLUSH_CAP: state_next = pdmq_pkg::ST_REPORT;
            pdmq_pkg::ST_REPORT:    state_next = pdmq_pkg::ST_IDLE;
            default:                state_next = pdmq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            pdmq_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            pdmq_pkg::ST_DECODE:
            begin
                cmd.init  = 1'b1;
                cmd.clear = (sts.action == pdmq_pkg::ACT_CLEAR);
            end
            pdmq_pkg::ST_SCAN:      cmd.scan      = 1'b1;
            pdmq_pkg::ST_PICK:      cmd.pick      = 1'b1;
            pdmq_pkg::ST_SHIFT:     cmd.shift     = 1'b1;
            pdmq_pkg::ST_APPEND:    cmd.append    = 1'b1;
            pdmq_pkg::ST_FLUSH_RD:  cmd.flush_rd  = 1'b1;
            pdmq_pkg::ST_FLUSH_CAP: cmd.flush_cap = 1'b1;
            pdmq_pkg::ST_REPORT:    cmd.report    = 1'b1;
            default:                busy          = 1'b1;
        endcase
    end

endmodule

### hw/rtl/pdmq_datapath.sv
// Queue storage, pointers, eviction search and result registers.
module pdmq_datapath #(
    parameter int unsigned DEPTH = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pdmq_pkg::cmd_t    cmd,
    output pdmq_pkg::status_t sts,
    input  logic              cfg_we,
    input  logic [9:0]        cfg_data,
    input  logic [1:0]        action,
    input  logic [2:0]        msg_type,
    input  logic [31:0]       client_id,
    input  logic [31:0]       payload_tag,
    output logic              done,
    output logic              out_valid,
    output logic [2:0]        out_type,
    output logic [31:0]       out_client,
    output logic [31:0]       out_payload,
    output logic              accepted,
    output logic              evicted,
    output logic [2:0]        evicted_type,
    output logic              queue_empty,
    output logic [9:0]        queue_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [9:0]    max_reg;
    logic [CW-1:0] cnt_reg, idx_reg, ridx_reg, dpos_reg, mpos_reg;
    logic [AW-1:0] head_reg;
    logic          rv_reg, fd_reg, fm_reg, done_reg;
    logic [2:0]    mtype_reg;
    logic [1:0]    act_reg;
    logic [2:0]    typ_reg;
    logic [31:0]   cli_reg, pay_reg;
    logic          ov_reg, acc_reg, ev_reg;
    logic [2:0]    ot_reg, evt_reg;
    logic [31:0]   oc_reg, op_reg;
    logic [CW-1:0] qc_reg;

    logic                        issue, we, mhit;
    logic [AW-1:0]               raddr, waddr;
    logic [pdmq_pkg::ENTRY_W-1:0] wdata, rdata;
    logic [2:0]                  rtype;
    logic [CW-1:0]               tail;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(i);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign issue = (cmd.scan || cmd.shift) && (idx_reg < cnt_reg);
    assign rtype = rdata[pdmq_pkg::ENTRY_W-1 -: 3];
    assign mhit  = (rtype >= pdmq_pkg::SEV_INFO) && (rtype < typ_reg)
                   && (typ_reg <= pdmq_pkg::SEV_CRITICAL);
    assign tail  = cnt_reg - CW'(ev_reg);
    assign raddr = cmd.flush_rd ? head_reg : phys(head_reg, idx_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = phys(head_reg, tail);
        wdata = {typ_reg, cli_reg, pay_reg};
        if (cmd.shift && rv_reg)
        begin
            we    = 1'b1;
            waddr = phys(head_reg, ridx_reg - CW'(1));
            wdata = rdata;
        end
        else if (cmd.append)
        begin
            we = 1'b1;
        end
    end

    pdmq_ram #(
        .WIDTH(pdmq_pkg::ENTRY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        sts.action     = act_reg;
        sts.room       = (cnt_reg < CW'(DEPTH)) && ({22'd0, max_reg} > 32'(cnt_reg));
        sts.empty      = (cnt_reg == '0);
        sts.sweep_done = (idx_reg >= cnt_reg) && !rv_reg;
        sts.found      = fd_reg || fm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= pdmq_pkg::MAX_SIZE_RESET;
            cnt_reg  <= '0;
            head_reg <= '0;
            rv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            rv_reg   <= issue;
            done_reg <= cmd.report;
            if (cmd.clear)
            begin
                cnt_reg  <= '0;
                head_reg <= '0;
            end
            else if (cmd.append)
            begin
                cnt_reg <= tail + CW'(1);
            end
            else if (cmd.flush_cap)
            begin
                cnt_reg  <= cnt_reg - CW'(1);
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            end
        end
    end

    // payload and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            typ_reg <= msg_type;
            cli_reg <= client_id;
            pay_reg <= payload_tag;
            ov_reg  <= 1'b0;
            ot_reg  <= '0;
            oc_reg  <= '0;
            op_reg  <= '0;
            acc_reg <= 1'b0;
            ev_reg  <= 1'b0;
            evt_reg <= '0;
        end
        if (cmd.init)
        begin
            idx_reg <= '0;
            fd_reg  <= 1'b0;
            fm_reg  <= 1'b0;
        end
        if (issue)
        begin
            idx_reg  <= idx_reg + CW'(1);
            ridx_reg <= idx_reg;
        end
        if (cmd.scan && rv_reg)
        begin
            if (rtype == pdmq_pkg::SEV_DATA && !fd_reg)
            begin
                fd_reg   <= 1'b1;
                dpos_reg <= ridx_reg;
            end
            if (mhit && !fm_reg)
            begin
                fm_reg    <= 1'b1;
                mpos_reg  <= ridx_reg;
                mtype_reg <= rtype;
            end
        end
        if (cmd.pick && (fd_reg || fm_reg))
        begin
            ev_reg  <= 1'b1;
            evt_reg <= fd_reg ? pdmq_pkg::SEV_DATA : mtype_reg;
            idx_reg <= (fd_reg ? dpos_reg : mpos_reg) + CW'(1);
        end
        if (cmd.append)
        begin
            acc_reg <= 1'b1;
        end
        if (cmd.flush_cap)
        begin
            ov_reg <= 1'b1;
            ot_reg <= rtype;
            oc_reg <= rdata[63:32];
            op_reg <= rdata[31:0];
        end
        if (cmd.report)
        begin
            qc_reg <= cnt_reg;
        end
    end

    assign done         = done_reg;
    assign out_valid    = ov_reg;
    assign out_type     = ot_reg;
    assign out_client   = oc_reg;
    assign out_payload  = op_reg;
    assign accepted     = acc_reg;
    assign evicted      = ev_reg;
    assign evicted_type = evt_reg;
    assign queue_empty  = (qc_reg == '0);
    assign queue_count  = 10'(qc_reg);

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("entry count beyond depth");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("result strobe longer than one cycle");
    a_evict_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ev_reg) |-> acc_reg) else $error("eviction without append");
    a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> $past(cmd.scan || cmd.shift)) else $error("stray read data");
`endif

endmodule

### sim/pdmq_checker.sv
// Checker for the message queue: predicts each request's result and compares it.
module pdmq_checker #(
    parameter int unsigned DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  msg_type,
    input  logic [31:0] client_id,
    input  logic [31:0] payload_tag,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        done,
    input  logic        out_valid,
    input  logic [2:0]  out_type,
    input  logic [31:0] out_client,
    input  logic [31:0] out_payload,
    input  logic        accepted,
    input  logic        evicted,
    input  logic [2:0]  evicted_type,
    input  logic        queue_empty,
    input  logic [9:0]  queue_count,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SEV_WARNING = 3'd2;
    localparam logic [2:0] SEV_ERROR   = 3'd3;
    localparam int         BOOK_SLOTS  = 4;

    typedef struct {
        logic        popped;
        logic [2:0]  sev;
        logic [31:0] client;
        logic [31:0] payload;
        logic        appended;
        logic        removed;
        logic [2:0]  removed_sev;
        logic        empty;
        logic [9:0]  count;
    } outcome_t;

    logic [2:0]  sev_q     [DEPTH];
    logic [31:0] client_q  [DEPTH];
    logic [31:0] payload_q [DEPTH];
    int          depth_now;
    logic [9:0]  size_limit;
    outcome_t    book [BOOK_SLOTS];
    int          book_rd;
    int          book_wr;

    function automatic int oldest_with(logic [7:0] mask);
        for (int i = 0; i < depth_now; i++)
            if (mask[sev_q[i]])
                return i;
        return depth_now;
    endfunction

    function automatic void remove_at(int pos);
        for (int i = pos; i < depth_now - 1; i++)
        begin
            sev_q[i]     = sev_q[i + 1];
            client_q[i]  = client_q[i + 1];
            payload_q[i] = payload_q[i + 1];
        end
        depth_now--;
    endfunction

    function automatic outcome_t queue_step(logic [1:0] act, logic [2:0] sev,
                                            logic [31:0] client, logic [31:0] payload);
        outcome_t   r;
        int         lim;
        int         pos;
        bit         room;
        logic [7:0] mask;
        r = '{default: '0};
        if (act == pdmq_pkg::ACT_ADD)
        begin
            lim  = (size_limit < DEPTH) ? size_limit : DEPTH;
            room = depth_now < lim;
            if (!room)
            begin
                mask = '0;
                pos  = oldest_with(8'(1) << pdmq_pkg::SEV_DATA);
                if (pos >= depth_now)
                begin
                    if (sev == SEV_WARNING)
                        mask[pdmq_pkg::SEV_INFO] = 1'b1;
                    else if (sev == SEV_ERROR)
                        mask = (8'(1) << pdmq_pkg::SEV_INFO) | (8'(1) << SEV_WARNING);
                    else if (sev == pdmq_pkg::SEV_CRITICAL)
                        mask = (8'(1) << pdmq_pkg::SEV_INFO) | (8'(1) << SEV_WARNING)
                             | (8'(1) << SEV_ERROR);
                    pos = oldest_with(mask);
                end
                if (pos < depth_now)
                begin
                    r.removed     = 1'b1;
                    r.removed_sev = sev_q[pos];
                    remove_at(pos);
                    room = 1'b1;
                end
            end
            if (room && depth_now < DEPTH)
            begin
                sev_q[depth_now]     = sev;
                client_q[depth_now]  = client;
                payload_q[depth_now] = payload;
                depth_now++;
                r.appended = 1'b1;
            end
        end
        else if (act == pdmq_pkg::ACT_FLUSH)
        begin
            if (depth_now > 0)
            begin
                r.popped  = 1'b1;
                r.sev     = sev_q[0];
                r.client  = client_q[0];
                r.payload = payload_q[0];
                remove_at(0);
            end
        end
        else if (act == pdmq_pkg::ACT_CLEAR)
            depth_now = 0;
        r.empty = depth_now == 0;
        r.count = 10'(depth_now);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            depth_now  = 0;
            size_limit = pdmq_pkg::MAX_SIZE_RESET;
            book_rd    = 0;
            book_wr    = 0;
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (book_wr == book_rd)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = book[book_rd % BOOK_SLOTS];
                    book_rd++;
                    if (out_valid !== want.popped)
                    begin
                        $error("out_valid: expected %0d, got %0d", want.popped, out_valid);
                        errors++;
                    end
                    if (out_type !== want.sev)
                    begin
                        $error("out_type: expected %0d, got %0d", want.sev, out_type);
                        errors++;
                    end
                    if (out_client !== want.client)
                    begin
                        $error("out_client: expected %h, got %h", want.client, out_client);
                        errors++;
                    end
                    if (out_payload !== want.payload)
                    begin
                        $error("out_payload: expected %h, got %h", want.payload,
                               out_payload);
                        errors++;
                    end
                    if (accepted !== want.appended)
                    begin
                        $error("accepted: expected %0d, got %0d", want.appended, accepted);
                        errors++;
                    end
                    if (evicted !== want.removed)
                    begin
                        $error("evicted: expected %0d, got %0d", want.removed, evicted);
                        errors++;
                    end
                    if (evicted_type !== want.removed_sev)
                    begin
                        $error("evicted_type: expected %0d, got %0d", want.removed_sev,
                               evicted_type);
                        errors++;
                    end
                    if (queue_empty !== want.empty)
                    begin
                        $error("queue_empty: expected %0d, got %0d", want.empty, queue_empty);
                        errors++;
                    end
                    if (queue_count !== want.count)
                    begin
                        $error("queue_count: expected %0d, got %0d", want.count, queue_count);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                size_limit = cfg_data;
            if (start && !busy)
            begin
                if (book_wr - book_rd >= BOOK_SLOTS)
                begin
                    $error("too many requests outstanding");
                    errors++;
                end
                book[book_wr % BOOK_SLOTS] = queue_step(action, msg_type, client_id,
                                                        payload_tag);
                book_wr++;
            end
            pending = book_wr - book_rd;
        end
    end
endmodule

### sim/tb.sv
// Testbench top: drives requests and size settings, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NOP  = 2'd3;
    localparam int         IDLE_MAX = 6000;
    localparam logic [9:0] LIMITS [12] = '{10'd4, 10'd1, 10'd0, 10'd7, 10'd3, 10'd1023,
                                           10'd2, 10'd16, 10'd512, 10'd5, 10'd1, 10'd10};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = pdmq_pkg::ACT_ADD;
    logic [2:0]  msg_type = pdmq_pkg::SEV_DATA;
    logic [31:0] client_id = '0;
    logic [31:0] payload_tag = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;
    logic        done;
    logic        out_valid;
    logic [2:0]  out_type;
    logic [31:0] out_client;
    logic [31:0] out_payload;
    logic        accepted;
    logic        evicted;
    logic [2:0]  evicted_type;
    logic        queue_empty;
    logic [9:0]  queue_count;
    int          pending;
    int          errors;
    int          quiet_cycles = 0;
    bit          gaps_on = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    priority_drop_message_queue_top dut (.*);

    pdmq_checker chk (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Leave start high after acceptance; a random gap before the next request or a drain lowers it.
    task automatic send_request(logic [1:0] act, logic [2:0] sev,
                                logic [31:0] client, logic [31:0] payload);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action      = act;
        msg_type    = sev;
        client_id   = client;
        payload_tag = payload;
        start       = 1'b1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        wait (pending == 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_limit(logic [9:0] lim);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = lim;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_request();
        int          pick;
        logic [1:0]  act;
        logic [2:0]  sev;
        pick = $urandom_range(0, 99);
        if (pick < 66)
            act = pdmq_pkg::ACT_ADD;
        else if (pick < 92)
            act = pdmq_pkg::ACT_FLUSH;
        else if (pick < 96)
            act = pdmq_pkg::ACT_CLEAR;
        else
            act = ACT_NOP;
        sev = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        send_request(act, sev, $urandom, $urandom);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Default size: every severity, unknown ones too, extreme ids and tags.
        send_request(pdmq_pkg::ACT_FLUSH, pdmq_pkg::SEV_DATA, '0, '0);
        for (int s = 0; s < 8; s++)
            send_request(pdmq_pkg::ACT_ADD, 3'(s), (s % 2) ? '1 : '0, (s % 2) ? '0 : '1);
        send_request(ACT_NOP, pdmq_pkg::SEV_DATA, '1, '1);
        send_request(pdmq_pkg::ACT_FLUSH, pdmq_pkg::SEV_DATA, '0, '0);
        send_request(pdmq_pkg::ACT_FLUSH, pdmq_pkg::SEV_DATA, '0, '0);
        send_request(pdmq_pkg::ACT_CLEAR, pdmq_pkg::SEV_DATA, '0, '0);
        send_request(pdmq_pkg::ACT_FLUSH, pdmq_pkg::SEV_DATA, '0, '0);

        // Tiny queue: eviction by rank, then a drop with nothing to evict.
        set_limit(10'd2);
        send_request(pdmq_pkg::ACT_ADD, pdmq_pkg::SEV_INFO, 32'h1, 32'h10);
        send_request(pdmq_pkg::ACT_ADD, 3'(pdmq_pkg::SEV_INFO + 1), 32'h2, 32'h20);
        send_request(pdmq_pkg::ACT_ADD, 3'(pdmq_pkg::SEV_INFO + 2), 32'h3, 32'h30);
        send_request(pdmq_pkg::ACT_ADD, pdmq_pkg::SEV_CRITICAL, 32'h4, 32'h40);
        send_request(pdmq_pkg::ACT_ADD, pdmq_pkg::SEV_CRITICAL, 32'h5, 32'h50);
        send_request(pdmq_pkg::ACT_ADD, 3'd7, 32'h6, 32'h60);
        set_limit(10'd0);
        send_request(pdmq_pkg::ACT_ADD, pdmq_pkg::SEV_CRITICAL, 32'h7, 32'h70);
        send_request(pdmq_pkg::ACT_CLEAR, pdmq_pkg::SEV_DATA, '0, '0);
        send_request(pdmq_pkg::ACT_ADD, pdmq_pkg::SEV_DATA, 32'h8, 32'h80);

        foreach (LIMITS[p])
        begin
            set_limit(LIMITS[p]);
            gaps_on = $urandom_range(0, 2) != 0;
            for (int i = 0; i < 46; i++)
            begin
                if (p == 6 && i == 23)
                    drain();
                random_request();
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
